// File: sv/modbus_rtu_frame_responder_macros.svh
// Assertion macros used by the frame responder back end.
`ifndef MODBUS_RTU_FRAME_RESPONDER_MACROS_SVH
`define MODBUS_RTU_FRAME_RESPONDER_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, pre, post)

`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// File: sv/mrfr_pkg.sv
// Shared types, constants and the CRC byte update of the frame responder.
package mrfr_pkg;

   localparam int RxBufSizeDefault = 256;
   localparam int HdrLen = 10;
   localparam int HdrIdxWidth = 4;
   localparam int MinFrameLen = 4;
   localparam int OtaStartLen = 12;

   localparam int QueueDepth = 2;
   localparam int QueueIdxWidth = 1;

   localparam int ReplyIdxWidth = 3;
   localparam logic [ReplyIdxWidth-1:0] ReplyIdxDevice = 3'd0;
   localparam logic [ReplyIdxWidth-1:0] ReplyIdxFunc = 3'd1;
   localparam logic [ReplyIdxWidth-1:0] ReplyIdxSub1 = 3'd2;
   localparam logic [ReplyIdxWidth-1:0] ReplyIdxSub2 = 3'd3;
   localparam logic [ReplyIdxWidth-1:0] ReplyIdxCrcLow = 3'd4;
   localparam logic [ReplyIdxWidth-1:0] ReplyIdxCrcHigh = 3'd5;

   localparam int CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CsrOwnDeviceId = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrMatchAddress = 1'b1;
   localparam logic [7:0] OwnDeviceIdReset = 8'h01;
   localparam logic [7:0] MatchAddressReset = 8'h00;

   localparam logic OpRxByte = 1'b0;
   localparam logic OpFrameEnd = 1'b1;

   localparam logic [7:0] FuncHandshake = 8'h01;
   localparam logic [7:0] FuncOta = 8'h02;
   localparam logic [7:0] SubZero = 8'h00;
   localparam logic [7:0] SubOne = 8'h01;

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;

   localparam logic [2:0] StReplied = 3'd0;
   localparam logic [2:0] StValidNoReply = 3'd1;
   localparam logic [2:0] StBadLength = 3'd2;
   localparam logic [2:0] StCrcError = 3'd3;
   localparam logic [2:0] StAddrMismatch = 3'd4;
   localparam logic [2:0] StOtaTooShort = 3'd5;

   typedef struct packed {
      logic [7:0] own_device_id;
      logic [7:0] match_address;
   } cfg_type;

   typedef struct packed {
      logic        reply;
      logic [2:0]  status;
      logic [7:0]  func;
      logic [7:0]  sub1;
      logic [7:0]  sub2;
      logic        link;
      logic        is_start;
      logic [31:0] ota_size;
      logic [15:0] ota_crc;
   } job_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: sv/modbus_rtu_frame_responder.sv
// Top level of the Modbus RTU frame responder with its configuration registers.
//
// The req channel carries received UART bytes (opcode 0) and frame-end events
// (opcode 1, line idle). An item is taken when req_valid is high and req_stall
// is low. The front end takes one item per cycle while req_stall is low; bytes
// past RX_BUF_SIZE are dropped. A frame end after one or more bytes is
// classified in its own cycle and queued as a job. The rsp channel gives one
// status item per rejected or reply-less frame, or six items carrying the reply
// frame. A job passes through the queue, the job register and the single output
// register of the back end; reply items follow one per cycle while rsp_stall is
// low, and the next job leaves the two-entry queue only when the back end is idle.
// When rsp_stall is held the back end waits, the queue fills, and once it
// is full req_stall is raised until an entry drains.
// The csr channel is always ready; index 0 is own_device_id, index 1 is
// match_address. Reset clears the count, link flag, queue and output valid,
// sets the CRC to its initial value and loads the register reset values.
module modbus_rtu_frame_responder
   import mrfr_pkg::*;
#(
   parameter int RX_BUF_SIZE = RxBufSizeDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic [7:0]               req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_has_byte,
   output logic [7:0]               rsp_tx_byte,
   output logic                     rsp_last,
   output logic [2:0]               rsp_status,
   output logic                     rsp_link_state,
   output logic                     rsp_ota_begin,
   output logic [31:0]              rsp_ota_size,
   output logic [15:0]              rsp_ota_crc,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [7:0]               csr_wdata
);

   cfg_type cfg_ff;
   logic    q_push, q_full, q_pop, q_not_empty;
   job_type push_job, pop_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_device_id <= OwnDeviceIdReset;
         cfg_ff.match_address <= MatchAddressReset;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CsrOwnDeviceId) begin
            cfg_ff.own_device_id <= csr_wdata;
         end else if (csr_index == CsrMatchAddress) begin
            cfg_ff.match_address <= csr_wdata;
         end
      end
   end

   mrfr_front #(
      .RX_BUF_SIZE(RX_BUF_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_rx_byte(req_rx_byte),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   mrfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .not_empty(q_not_empty),
      .pop_job  (pop_job)
   );

   mrfr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_valid       (q_not_empty),
      .q_job         (pop_job),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_has_byte  (rsp_has_byte),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status),
      .rsp_link_state(rsp_link_state),
      .rsp_ota_begin (rsp_ota_begin),
      .rsp_ota_size  (rsp_ota_size),
      .rsp_ota_crc   (rsp_ota_crc)
   );

endmodule

// File: sv/mrfr_front.sv
// Front end: collects frame bytes, runs the CRC and classifies each frame end.
module mrfr_front
   import mrfr_pkg::*;
#(
   parameter int RX_BUF_SIZE = RxBufSizeDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_rx_byte,
   input  logic       q_full,
   output logic       q_push,
   output job_type    q_job
);

   localparam int CountWidth = $clog2(RX_BUF_SIZE + 1);

   logic [7:0]            hdr_ff [HdrLen];
   logic [CountWidth-1:0] count_ff, count_in;
   logic [15:0]           crc_ff, crc_in;
   logic                  link_ff, link_in;
   logic                  accept, take_byte, frame_end;
   job_type               job;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign frame_end = accept && (req_opcode == OpFrameEnd);
   assign take_byte = accept && (req_opcode == OpRxByte) && (count_ff < CountWidth'(RX_BUF_SIZE));
   assign q_push    = frame_end && (count_ff != '0);
   assign q_job     = job;

   always_comb begin
      job          = '0;
      job.func     = hdr_ff[1];
      job.sub1     = hdr_ff[2];
      job.sub2     = hdr_ff[3];
      job.status   = StValidNoReply;
      link_in      = link_ff;
      priority if (count_ff < CountWidth'(MinFrameLen)) begin
         job.status = StBadLength;
      end else if (crc_ff != 16'h0000) begin
         job.status = StCrcError;
      end else if (hdr_ff[0] != cfg.match_address) begin
         job.status = StAddrMismatch;
      end else if (hdr_ff[1] == FuncHandshake) begin
         if (hdr_ff[2] == SubZero && hdr_ff[3] == SubZero) begin
            job.reply = 1'b1;
         end else if (hdr_ff[2] == SubZero && hdr_ff[3] == SubOne) begin
            job.reply = 1'b1;
            link_in   = 1'b1;
         end else if (hdr_ff[2] == SubOne && hdr_ff[3] == SubOne) begin
            job.reply = 1'b1;
            link_in   = 1'b0;
         end
      end else if (hdr_ff[1] == FuncOta) begin
         if (hdr_ff[2] == SubZero && hdr_ff[3] == SubZero) begin
            if (count_ff < CountWidth'(OtaStartLen)) begin
               job.status = StOtaTooShort;
            end else begin
               job.reply    = 1'b1;
               job.is_start = 1'b1;
               job.ota_size = {hdr_ff[4], hdr_ff[5], hdr_ff[6], hdr_ff[7]};
               job.ota_crc  = {hdr_ff[8], hdr_ff[9]};
            end
         end else if (hdr_ff[2] == SubZero && hdr_ff[3] == SubOne) begin
            job.reply = 1'b1;
         end
      end
      if (job.reply) begin
         job.status = StReplied;
      end
      job.link = link_in;

      count_in = count_ff;
      crc_in   = crc_ff;
      if (frame_end) begin
         count_in = '0;
         crc_in   = CrcInit;
      end else if (take_byte) begin
         count_in = count_ff + CountWidth'(1);
         crc_in   = crc_feed(crc_ff, req_rx_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= CrcInit;
         link_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
         if (q_push) begin
            link_ff <= link_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_byte && count_ff < CountWidth'(HdrLen)) begin
         hdr_ff[count_ff[HdrIdxWidth-1:0]] <= req_rx_byte;
      end
   end

endmodule

// File: sv/mrfr_queue.sv
// Short job queue between the frame classifier and the reply sender.
module mrfr_queue
   import mrfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type pop_job
);

   job_type                  mem_ff [QueueDepth];
   logic [QueueIdxWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueueIdxWidth:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign full      = (count_ff == (QueueIdxWidth+1)'(QueueDepth));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QueueIdxWidth+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QueueIdxWidth+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QueueIdxWidth'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QueueIdxWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: sv/mrfr_back.sv
// Back end: turns queued jobs into status items or six-byte reply frames.
module mrfr_back
   import mrfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_valid,
   input  job_type     q_job,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_has_byte,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic [2:0]  rsp_status,
   output logic        rsp_link_state,
   output logic        rsp_ota_begin,
   output logic [31:0] rsp_ota_size,
   output logic [15:0] rsp_ota_crc
);

   `include "modbus_rtu_frame_responder_macros.svh"

   logic                     busy_ff, busy_in;
   logic [ReplyIdxWidth-1:0] idx_ff, idx_in;
   job_type                  job_ff, job_in;
   logic [15:0]              crc_ff, crc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     has_byte_ff, last_ff, ota_begin_ff, link_ff;
   logic [7:0]               tx_byte_ff;
   logic [2:0]               status_ff;
   logic [31:0]              ota_size_ff;
   logic [15:0]              ota_crc_ff;
   logic                     out_free, emit, item_last;
   logic [7:0]               cur_byte;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = !busy_ff && q_valid;
   assign emit      = busy_ff && out_free;
   assign item_last = !job_ff.reply || (idx_ff == ReplyIdxCrcHigh);

   always_comb begin
      unique case (idx_ff)
         ReplyIdxDevice:  cur_byte = cfg.own_device_id;
         ReplyIdxFunc:    cur_byte = job_ff.func;
         ReplyIdxSub1:    cur_byte = job_ff.sub1;
         ReplyIdxSub2:    cur_byte = job_ff.sub2;
         ReplyIdxCrcLow:  cur_byte = crc_ff[7:0];
         ReplyIdxCrcHigh: cur_byte = crc_ff[15:8];
         default:         cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      job_in       = job_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (q_pop) begin
         job_in  = q_job;
         busy_in = 1'b1;
         idx_in  = ReplyIdxDevice;
      end else if (emit) begin
         rsp_valid_in = 1'b1;
         if (item_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + ReplyIdxWidth'(1);
         end
         if (idx_ff < ReplyIdxCrcLow) begin
            crc_in = crc_feed((idx_ff == ReplyIdxDevice) ? CrcInit : crc_ff, cur_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      crc_ff <= crc_in;
      if (emit) begin
         has_byte_ff  <= job_ff.reply;
         tx_byte_ff   <= job_ff.reply ? cur_byte : 8'h00;
         last_ff      <= item_last;
         status_ff    <= job_ff.status;
         link_ff      <= job_ff.link;
         ota_begin_ff <= item_last && job_ff.is_start;
         ota_size_ff  <= (item_last && job_ff.reply) ? job_ff.ota_size : 32'h0;
         ota_crc_ff   <= (item_last && job_ff.reply) ? job_ff.ota_crc : 16'h0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_has_byte   = has_byte_ff;
   assign rsp_tx_byte    = tx_byte_ff;
   assign rsp_last       = last_ff;
   assign rsp_status     = status_ff;
   assign rsp_link_state = link_ff;
   assign rsp_ota_begin  = ota_begin_ff;
   assign rsp_ota_size   = ota_size_ff;
   assign rsp_ota_crc    = ota_crc_ff;

   `ASSERT_IMPLY(a_more_items_pending, clock, reset, rsp_valid_ff && !last_ff, busy_ff)
   `ASSERT_IMPLY(a_status_item_is_last, clock, reset, rsp_valid_ff && !has_byte_ff, last_ff)
   `ASSERT_IMPLY(a_ota_begin_on_last_byte, clock, reset, rsp_valid_ff && ota_begin_ff,
                 last_ff && has_byte_ff)
   `ASSERT_IMPLY(a_status_job_single_step, clock, reset, busy_ff && !job_ff.reply,
                 idx_ff == ReplyIdxDevice)
   `ASSERT_NEXT(a_reply_bytes_contiguous, clock, reset,
                rsp_valid_ff && !rsp_stall && !last_ff, rsp_valid_ff)

endmodule

// File: dv/modbus_rtu_frame_responder_test.sv
// Self-checking testbench for the Modbus RTU frame responder: frames in, replies and status out.
`timescale 1ns / 100ps

module modbus_rtu_frame_responder_test
   import mrfr_pkg::*;
();

   localparam int CycleLimit = 400000;
   localparam int HoldCycles = 400;

   typedef enum logic [1:0] {
      TailGood,
      TailBad,
      TailNone
   } tail_type;

   typedef struct packed {
      logic        has_byte;
      logic [7:0]  tx_byte;
      logic        last;
      logic [2:0]  status;
      logic        link_state;
      logic        ota_begin;
      logic [31:0] ota_size;
      logic [15:0] ota_crc;
   } frame_reply_type;

   typedef struct packed {
      logic [7:0]  dev_id;
      logic [7:0]  match_addr;
      logic [3:0]  body_len;
      logic [95:0] body;
      tail_type    tail;
      logic [7:0]  fill;
      logic [3:0]  spill;
      logic        typed;
      logic [2:0]  typed_status;
      logic        typed_link;
   } frame_row_type;

   localparam frame_row_type DirectedFrames [25] = '{
      '{8'h01, 8'h00, 4'd0, 96'h00000000_00000000_00000000, TailNone, 8'd0, 4'd0,
        1'b0, StReplied, 1'b0},
      '{8'h01, 8'h00, 4'd1, 96'hFF000000_00000000_00000000, TailNone, 8'd0, 4'd0,
        1'b1, StBadLength, 1'b0},
      '{8'h01, 8'h00, 4'd3, 96'h00010000_00000000_00000000, TailNone, 8'd0, 4'd0,
        1'b1, StBadLength, 1'b0},
      '{8'h01, 8'h00, 4'd4, 96'h00010001_00000000_00000000, TailBad, 8'd0, 4'd0,
        1'b1, StCrcError, 1'b0},
      '{8'h01, 8'h00, 4'd2, 96'h00010000_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b0, StReplied, 1'b0},
      '{8'h01, 8'h00, 4'd4, 96'h05010000_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b1, StAddrMismatch, 1'b0},
      '{8'h01, 8'h00, 4'd4, 96'h00010000_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b0, StReplied, 1'b0},
      '{8'h01, 8'h00, 4'd4, 96'h00010001_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b0, StReplied, 1'b0},
      '{8'h01, 8'h00, 4'd4, 96'h00010101_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b0, StReplied, 1'b0},
      '{8'h01, 8'h00, 4'd4, 96'h00010100_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b1, StValidNoReply, 1'b0},
      '{8'h01, 8'h00, 4'd4, 96'h00010001_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b0, StReplied, 1'b0},
      '{8'h01, 8'h00, 4'd4, 96'h00030000_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b1, StValidNoReply, 1'b1},
      '{8'h01, 8'h00, 4'd4, 96'h00FFFFFF_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b1, StValidNoReply, 1'b1},
      '{8'h01, 8'h00, 4'd8, 96'h00020000_12345678_00000000, TailGood, 8'd0, 4'd0,
        1'b1, StOtaTooShort, 1'b1},
      '{8'h01, 8'h00, 4'd9, 96'h00020000_AABBCCDD_EE000000, TailGood, 8'd0, 4'd0,
        1'b1, StOtaTooShort, 1'b1},
      '{8'h01, 8'h00, 4'd10, 96'h00020000_FFFFFFFF_FFFF0000, TailGood, 8'd0, 4'd0,
        1'b0, StReplied, 1'b0},
      '{8'h01, 8'h00, 4'd10, 96'h00020000_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b0, StReplied, 1'b0},
      '{8'h01, 8'h00, 4'd4, 96'h00020001_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b0, StReplied, 1'b0},
      '{8'h01, 8'h00, 4'd4, 96'h00020100_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b1, StValidNoReply, 1'b1},
      '{8'h01, 8'h00, 4'd10, 96'h00020000_01020304_05060000, TailBad, 8'd0, 4'd0,
        1'b1, StCrcError, 1'b1},
      '{8'h01, 8'h00, 4'd4, 96'h00010101_00000000_00000000, TailGood, 8'd250, 4'd6,
        1'b0, StReplied, 1'b0},
      '{8'hFF, 8'hFF, 4'd4, 96'hFF010000_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b0, StReplied, 1'b0},
      '{8'hFF, 8'hFF, 4'd4, 96'h00010000_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b1, StAddrMismatch, 1'b0},
      '{8'h00, 8'h80, 4'd4, 96'h80020001_00000000_00000000, TailGood, 8'd0, 4'd0,
        1'b0, StReplied, 1'b0},
      '{8'h00, 8'h80, 4'd4, 96'h80010001_00000000_00000000, TailGood, 8'd3, 4'd0,
        1'b0, StReplied, 1'b0}
   };

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_opcode = OpRxByte;
   logic [7:0]               req_rx_byte = 8'h00;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_has_byte;
   logic [7:0]               rsp_tx_byte;
   logic                     rsp_last;
   logic [2:0]               rsp_status;
   logic                     rsp_link_state;
   logic                     rsp_ota_begin;
   logic [31:0]              rsp_ota_size;
   logic [15:0]              rsp_ota_crc;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = CsrOwnDeviceId;
   logic [7:0]               csr_wdata = 8'h00;

   // A typed expectation travels with its frame-end item.
   logic                     typed_on = 1'b0;
   frame_reply_type          typed_item = '0;

   logic [7:0]               hdr_bytes [HdrLen];
   logic [8:0]               rx_count = '0;
   logic [15:0]              rx_crc = CrcInit;
   logic                     link_up = 1'b0;
   logic [7:0]               cfg_dev = OwnDeviceIdReset;
   logic [7:0]               cfg_match = MatchAddressReset;

   frame_reply_type          due_replies [$];
   frame_reply_type          new_replies [$];
   logic [7:0]               frame_bytes [$];

   int                       mismatches = 0;
   int                       live_items = 0;
   int                       cycle_count = 0;
   int                       gap_odds = 4;
   int                       stall_odds = 4;
   int                       hold_requests = 0;
   int                       holds_done = 0;

   modbus_rtu_frame_responder u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status),
      .rsp_link_state (rsp_link_state),
      .rsp_ota_begin  (rsp_ota_begin),
      .rsp_ota_size   (rsp_ota_size),
      .rsp_ota_crc    (rsp_ota_crc),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {8'h00, b};
      repeat (8) acc = acc[0] ? ((acc >> 1) ^ CrcPoly) : (acc >> 1);
      return acc;
   endfunction

   function automatic logic [7:0] pick_sub();
      case ($urandom_range(0, 2))
         0: return SubZero;
         1: return SubOne;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void predict_frame_event(input logic op, input logic [7:0] b);
      logic [8:0]      len;
      logic [15:0]     residue;
      logic [15:0]     reply_crc;
      logic [7:0]      reply [6];
      logic            send;
      logic            start;
      logic            too_short;
      frame_reply_type item;
      new_replies.delete();
      if (op == OpRxByte) begin
         if (rx_count < RxBufSizeDefault) begin
            if (rx_count < HdrLen) hdr_bytes[rx_count[HdrIdxWidth-1:0]] = b;
            rx_crc = crc16_step(rx_crc, b);
            rx_count = rx_count + 1'b1;
         end
         return;
      end
      len = rx_count;
      residue = rx_crc;
      rx_count = '0;
      rx_crc = CrcInit;
      if (len == 0) return;
      item = '0;
      item.last = 1'b1;
      if (len < MinFrameLen) begin
         item.status = StBadLength;
      end else if (residue != 16'h0000) begin
         item.status = StCrcError;
      end else if (hdr_bytes[0] != cfg_match) begin
         item.status = StAddrMismatch;
      end else begin
         send = 1'b0;
         start = 1'b0;
         too_short = 1'b0;
         case (hdr_bytes[1])
            FuncHandshake: begin
               if (hdr_bytes[2] == SubZero && hdr_bytes[3] == SubZero) begin
                  send = 1'b1;
               end else if (hdr_bytes[2] == SubZero && hdr_bytes[3] == SubOne) begin
                  send = 1'b1;
                  link_up = 1'b1;
               end else if (hdr_bytes[2] == SubOne && hdr_bytes[3] == SubOne) begin
                  send = 1'b1;
                  link_up = 1'b0;
               end
            end
            FuncOta: begin
               if (hdr_bytes[2] == SubZero && hdr_bytes[3] == SubZero) begin
                  if (len < OtaStartLen) too_short = 1'b1;
                  else begin
                     send = 1'b1;
                     start = 1'b1;
                  end
               end else if (hdr_bytes[2] == SubZero && hdr_bytes[3] == SubOne) begin
                  send = 1'b1;
               end
            end
            default: ;
         endcase
         if (too_short) item.status = StOtaTooShort;
         else if (!send) item.status = StValidNoReply;
         else begin
            reply[0] = cfg_dev;
            reply[1] = hdr_bytes[1];
            reply[2] = hdr_bytes[2];
            reply[3] = hdr_bytes[3];
            reply_crc = CrcInit;
            for (int k = 0; k < 4; k++) reply_crc = crc16_step(reply_crc, reply[k]);
            reply[4] = reply_crc[7:0];
            reply[5] = reply_crc[15:8];
            for (int k = 0; k < 6; k++) begin
               item = '0;
               item.has_byte = 1'b1;
               item.tx_byte = reply[k];
               item.status = StReplied;
               item.link_state = link_up;
               if (k == 5) begin
                  item.last = 1'b1;
                  if (start) begin
                     item.ota_begin = 1'b1;
                     item.ota_size = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
                     item.ota_crc = {hdr_bytes[8], hdr_bytes[9]};
                  end
               end
               new_replies.push_back(item);
            end
            return;
         end
      end
      item.link_state = link_up;
      new_replies.push_back(item);
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) note_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
   endtask

   task automatic check_reply(input frame_reply_type got);
      frame_reply_type want;
      if (due_replies.size() == 0) begin
         note_mismatch($sformatf("item with nothing due (byte %0h, status %0d)",
                                 got.tx_byte, got.status));
         return;
      end
      want = due_replies.pop_front();
      cmp_field("has_byte", got.has_byte, want.has_byte);
      cmp_field("tx_byte", got.tx_byte, want.tx_byte);
      cmp_field("last", got.last, want.last);
      cmp_field("status", got.status, want.status);
      cmp_field("link_state", got.link_state, want.link_state);
      cmp_field("ota_begin", got.ota_begin, want.ota_begin);
      cmp_field("ota_size", got.ota_size, want.ota_size);
      cmp_field("ota_crc", got.ota_crc, want.ota_crc);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrOwnDeviceId: cfg_dev = csr_wdata;
               CsrMatchAddress: cfg_match = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if ((req_opcode == OpRxByte && rx_count < RxBufSizeDefault) ||
                (req_opcode == OpFrameEnd && rx_count != 0)) live_items++;
            predict_frame_event(req_opcode, req_rx_byte);
            if (typed_on && req_opcode == OpFrameEnd) due_replies.push_back(typed_item);
            else foreach (new_replies[i]) due_replies.push_back(new_replies[i]);
         end
         if (rsp_valid && !rsp_stall) begin
            check_reply({rsp_has_byte, rsp_tx_byte, rsp_last, rsp_status, rsp_link_state,
                         rsp_ota_begin, rsp_ota_size, rsp_ota_crc});
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("modbus_rtu_frame_responder regression: fail");
         $finish;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            rsp_stall <= 1'b1;
            for (int n = 0; n < HoldCycles; n++) @(posedge clock);
            holds_done++;
            rsp_stall <= 1'b0;
         end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic offer(input logic op, input logic [7:0] b, input logic typed,
                        input frame_reply_type t);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_rx_byte <= b;
      typed_on <= typed;
      typed_item <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic transmit_frame(input tail_type tail, input int fill, input int spill,
                                 input logic typed, input frame_reply_type t);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = CrcInit;
      foreach (frame_bytes[i]) begin
         offer(OpRxByte, frame_bytes[i], 1'b0, '0);
         crc = crc16_step(crc, frame_bytes[i]);
      end
      repeat (fill) begin
         b = 8'($urandom_range(0, 255));
         offer(OpRxByte, b, 1'b0, '0);
         crc = crc16_step(crc, b);
      end
      if (tail == TailBad) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
      if (tail != TailNone) begin
         offer(OpRxByte, crc[7:0], 1'b0, '0);
         offer(OpRxByte, crc[15:8], 1'b0, '0);
      end
      repeat (spill) offer(OpRxByte, 8'($urandom_range(0, 255)), 1'b0, '0);
      offer(OpFrameEnd, 8'($urandom_range(0, 255)), typed, t);
   endtask

   task automatic random_frame(input logic [7:0] match);
      logic [7:0] func;
      logic [7:0] sub1;
      logic [7:0] sub2;
      int         extra;
      int         fill;
      int         spill;
      int         roll;
      tail_type   tail;
      frame_bytes.delete();
      fill = 0;
      spill = 0;
      if ($urandom_range(0, 4) != 0) begin
         case ($urandom_range(0, 7))
            0: begin func = FuncHandshake; sub1 = SubZero; sub2 = SubZero; extra = 0; end
            1: begin func = FuncHandshake; sub1 = SubZero; sub2 = SubOne; extra = 0; end
            2: begin func = FuncHandshake; sub1 = SubOne; sub2 = SubOne; extra = 0; end
            3: begin func = FuncHandshake; sub1 = pick_sub(); sub2 = pick_sub(); extra = 0; end
            4: begin func = FuncOta; sub1 = SubZero; sub2 = SubZero;
               extra = $urandom_range(6, 8); end
            5: begin func = FuncOta; sub1 = SubZero; sub2 = SubZero;
               extra = $urandom_range(0, 5); end
            6: begin func = FuncOta; sub1 = SubZero; sub2 = SubOne;
               extra = $urandom_range(0, 2); end
            default: begin
               func = ($urandom_range(0, 1) == 0) ? pick_sub() : 8'($urandom_range(0, 255));
               if (func == SubOne && $urandom_range(0, 1) == 0) func = FuncOta;
               sub1 = pick_sub();
               sub2 = pick_sub();
               extra = $urandom_range(0, 4);
            end
         endcase
         frame_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : match);
         frame_bytes.push_back(func);
         frame_bytes.push_back(sub1);
         frame_bytes.push_back(sub2);
         repeat (extra) frame_bytes.push_back(8'($urandom_range(0, 255)));
         roll = $urandom_range(0, 99);
         tail = (roll < 90) ? TailGood : (roll < 97) ? TailBad : TailNone;
         if ($urandom_range(0, 79) == 0) begin
            fill = 254 - frame_bytes.size();
            spill = $urandom_range(1, 8);
         end else if ($urandom_range(0, 7) == 0) begin
            fill = $urandom_range(1, 6);
         end
      end else begin
         repeat ($urandom_range(0, 14)) frame_bytes.push_back(8'($urandom_range(0, 255)));
         tail = tail_type'($urandom_range(0, 2));
      end
      transmit_frame(tail, fill, spill, 1'b0, '0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_regs(input logic [7:0] dev, input logic [7:0] match);
      csr_valid <= 1'b1;
      for (int i = 0; i < 2; i++) begin
         csr_index <= (i == 0) ? CsrOwnDeviceId : CsrMatchAddress;
         csr_wdata <= (i == 0) ? dev : match;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      frame_row_type   row;
      frame_reply_type typed;
      logic [7:0]      cur_dev;
      logic [7:0]      cur_match;
      int              stop_at;
      cur_dev = OwnDeviceIdReset;
      cur_match = MatchAddressReset;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedFrames[r]) begin
         row = DirectedFrames[r];
         if (row.dev_id != cur_dev || row.match_addr != cur_match) begin
            settle();
            program_regs(row.dev_id, row.match_addr);
            cur_dev = row.dev_id;
            cur_match = row.match_addr;
         end
         frame_bytes.delete();
         for (int i = 0; i < row.body_len; i++) frame_bytes.push_back(row.body[95 - 8*i -: 8]);
         typed = '0;
         typed.last = 1'b1;
         typed.status = row.typed_status;
         typed.link_state = row.typed_link;
         transmit_frame(row.tail, row.fill, row.spill, row.typed, typed);
      end

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin cur_dev = 8'h00; cur_match = 8'h00; end
            1: begin cur_dev = 8'hFF; cur_match = 8'hFF; end
            default: begin
               cur_dev = 8'($urandom_range(0, 255));
               cur_match = 8'($urandom_range(0, 255));
            end
         endcase
         settle();
         program_regs(cur_dev, cur_match);
         gap_odds = (p == 5) ? 0 : $urandom_range(2, 12);
         stall_odds = (p == 5) ? 0 : $urandom_range(2, 12);
         if (p == 2) hold_requests++;
         stop_at = live_items + ((p == 2) ? 40 : 12);
         while (live_items < stop_at) random_frame(cur_match);
      end

      settle();
      if (mismatches == 0) begin
         $display("modbus_rtu_frame_responder regression: pass");
      end else begin
         $display("modbus_rtu_frame_responder regression: fail");
      end
      $finish;
   end

endmodule
